// File: hw/rtl/crc64bt_pkg.sv
// Package with the shared constants and types of the two-mode CRC-64 unit.
package crc64bt_pkg;

   localparam int unsigned CRC_WIDTH  = 64;
   localparam int unsigned BYTE_WIDTH = 8;

   // Mode codes of the configuration register.
   typedef enum logic {
      MODE_ECMA = 1'b0,
      MODE_ISO  = 1'b1
   } crc_mode_type;

   // Polynomials and initial values of the two modes.
   localparam logic [CRC_WIDTH-1:0] POLY_ECMA = 64'h42F0_E1EB_A9EA_3693;
   localparam logic [CRC_WIDTH-1:0] POLY_ISO  = 64'hD800_0000_0000_0000;
   localparam logic [CRC_WIDTH-1:0] INIT_ECMA = 64'h0000_0000_0000_0000;
   localparam logic [CRC_WIDTH-1:0] INIT_ISO  = 64'hFFFF_FFFF_FFFF_FFFF;

   // One request item as held in the input register.
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  start_flag;
      logic                  last_flag;
   } req_item_type;

endpackage

// File: hw/rtl/crc64bt_in_reg.sv
// Input register stage that captures one request per cycle while req_stall is low.
module crc64bt_in_reg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [crc64bt_pkg::BYTE_WIDTH-1:0] req_data_byte,
   input  logic                            req_start_flag,
   input  logic                            req_last_flag,
   input  logic                            advance,
   output logic                            stage_valid,
   output crc64bt_pkg::req_item_type       stage_item
);
   import crc64bt_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   // The stage holds its request until the CRC stage takes it.
   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;
   assign valid_in  = req_stall ? 1'b1 : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.data_byte  <= req_data_byte;
         item_ff.start_flag <= req_start_flag;
         item_ff.last_flag  <= req_last_flag;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

// File: hw/rtl/crc64bt_core.sv
// CRC state register and the byte-wide update logic for both modes.
module crc64bt_core (
   input  logic                               clock,
   input  logic                               reset,
   input  crc64bt_pkg::crc_mode_type          mode,
   input  logic                               advance,
   input  crc64bt_pkg::req_item_type          item,
   output logic [crc64bt_pkg::CRC_WIDTH-1:0]  crc_final
);
   import crc64bt_pkg::*;

   logic [CRC_WIDTH-1:0] crc_ff;
   logic [CRC_WIDTH-1:0] crc_in;
   logic [CRC_WIDTH-1:0] poly;
   logic [CRC_WIDTH-1:0] init;
   logic [CRC_WIDTH-1:0] work;

   assign poly = (mode == MODE_ISO) ? POLY_ISO : POLY_ECMA;
   assign init = (mode == MODE_ISO) ? INIT_ISO : INIT_ECMA;

   // Reload on start, fold in the byte, then eight LSB-first shift steps.
   always_comb begin
      work = item.start_flag ? init : crc_ff;
      work = work ^ {{(CRC_WIDTH-BYTE_WIDTH){1'b0}}, item.data_byte};
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         if (work[0]) begin
            work = (work >> 1) ^ poly;
         end else begin
            work = work >> 1;
         end
      end
      crc_in = work;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
      end else if (advance) begin
         crc_ff <= crc_in;
      end
   end

   // ISO mode inverts the final value; ECMA mode passes it through.
   assign crc_final = (mode == MODE_ISO) ? (crc_in ^ INIT_ISO) : crc_in;

endmodule

// File: hw/rtl/crc64bt_out_reg.sv
// Result register that holds a finished CRC until the consumer takes it.
module crc64bt_out_reg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [crc64bt_pkg::CRC_WIDTH-1:0]  crc_final,
   output logic                               out_free,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [crc64bt_pkg::CRC_WIDTH-1:0]  rsp_crc_value
);
   import crc64bt_pkg::*;

   logic                 valid_ff;
   logic [CRC_WIDTH-1:0] crc_ff;

   // The register can take a new result when empty or being drained.
   assign out_free = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         crc_ff <= crc_final;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_crc_value = crc_ff;

endmodule

// File: hw/rtl/crc64_bytewise_two_mode_unit.sv
// Top level of the byte-wide CRC-64 unit with ECMA and ISO modes.
// A request waits in the input register; a last byte's result moves to the
// result register. Throughput: one request per cycle while req_stall is low;
// a byte's eight bit steps are combinational between the input register and
// the CRC/result registers. Reset (synchronous, active high) clears the CRC
// register and the mode to ECMA, and empties both pipeline registers.
module crc64_bytewise_two_mode_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic                               csr_crc_mode,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [crc64bt_pkg::BYTE_WIDTH-1:0] req_data_byte,
   input  logic                               req_start_flag,
   input  logic                               req_last_flag,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [crc64bt_pkg::CRC_WIDTH-1:0]  rsp_crc_value
);
   import crc64bt_pkg::*;

   crc_mode_type         mode_ff;
   logic                 stage_valid;
   req_item_type         stage_item;
   logic                 out_free;
   logic                 advance;
   logic [CRC_WIDTH-1:0] crc_final;

   // Mode register written through the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ECMA;
      end else if (csr_write_enable) begin
         mode_ff <= crc_mode_type'(csr_crc_mode);
      end
   end

   // A request moves on unless it carries a result that cannot be stored.
   assign advance = stage_valid && (!stage_item.last_flag || out_free);

   crc64bt_in_reg u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_start_flag (req_start_flag),
      .req_last_flag  (req_last_flag),
      .advance        (advance),
      .stage_valid    (stage_valid),
      .stage_item     (stage_item)
   );

   crc64bt_core u_core (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .advance   (advance),
      .item      (stage_item),
      .crc_final (crc_final)
   );

   crc64bt_out_reg u_out_reg (
      .clock         (clock),
      .reset         (reset),
      .load          (advance && stage_item.last_flag),
      .crc_final     (crc_final),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_crc_value (rsp_crc_value)
   );

endmodule

// File: tb/sv/crc64_two_mode_checker.sv
// Checker that predicts the CRC results of the two-mode CRC-64 unit and compares them.
module crc64_two_mode_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic                               csr_crc_mode,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [crc64bt_pkg::BYTE_WIDTH-1:0] req_data_byte,
   input  logic                               req_start_flag,
   input  logic                               req_last_flag,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [crc64bt_pkg::CRC_WIDTH-1:0]  rsp_crc_value,
   output int unsigned                        mismatch_count,
   output int unsigned                        crcs_pending,
   output int unsigned                        crcs_checked
);
   import crc64bt_pkg::*;

   localparam int unsigned PRINT_LIMIT = 50;

   // Shadow copy of the mode register and the running CRC register.
   crc_mode_type         shadow_mode;
   logic [CRC_WIDTH-1:0] running_crc;
   logic [CRC_WIDTH-1:0] expected_crc_q[$];
   int unsigned          fail_total;
   int unsigned          checked_total;

   initial begin
      shadow_mode    = MODE_ECMA;
      running_crc    = '0;
      fail_total     = 0;
      checked_total  = 0;
      mismatch_count = 0;
      crcs_pending   = 0;
      crcs_checked   = 0;
   end

   // Absorbs one byte at the low end, then runs eight reflected shift steps.
   function automatic logic [CRC_WIDTH-1:0] crc_after_byte(
      input logic [CRC_WIDTH-1:0]  crc_in,
      input logic [BYTE_WIDTH-1:0] data,
      input logic [CRC_WIDTH-1:0]  poly
   );
      logic [CRC_WIDTH-1:0] crc;
      crc = crc_in ^ {{(CRC_WIDTH-BYTE_WIDTH){1'b0}}, data};
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         crc = crc[0] ? ((crc >> 1) ^ poly) : (crc >> 1);
      end
      return crc;
   endfunction

   // Prints one line per mismatch (up to a limit) and counts every one.
   task automatic report_crc_mismatch(
      input string                what,
      input logic [CRC_WIDTH-1:0] got,
      input logic [CRC_WIDTH-1:0] wanted
   );
      if (fail_total < PRINT_LIMIT) begin
         $display("[%0t] crc_value error: %s (got %h, wanted %h)", $time, what, got, wanted);
      end
      fail_total++;
   endtask

   // Everything is sampled at the rising edge, before the edge's updates land.
   always @(posedge clock) begin : watch_channels
      logic [CRC_WIDTH-1:0] poly;
      logic [CRC_WIDTH-1:0] wanted_crc;
      if (reset) begin
         shadow_mode = MODE_ECMA;
         running_crc = '0;
         expected_crc_q.delete();
      end else begin
         // A result leaving at this edge always belongs to an earlier request.
         if (rsp_valid && !rsp_stall) begin
            if (expected_crc_q.size() == 0) begin
               report_crc_mismatch("result with no request waiting", rsp_crc_value, '0);
            end else begin
               wanted_crc = expected_crc_q.pop_front();
               if (rsp_crc_value !== wanted_crc) begin
                  report_crc_mismatch("wrong value", rsp_crc_value, wanted_crc);
               end
               checked_total++;
            end
         end

         // An accepted request uses the mode in force before any write at this edge.
         if (req_valid && !req_stall) begin
            poly = (shadow_mode == MODE_ISO) ? POLY_ISO : POLY_ECMA;
            if (req_start_flag) begin
               running_crc = (shadow_mode == MODE_ISO) ? INIT_ISO : INIT_ECMA;
            end
            running_crc = crc_after_byte(running_crc, req_data_byte, poly);
            if (req_last_flag) begin
               expected_crc_q.push_back((shadow_mode == MODE_ISO) ? (running_crc ^ INIT_ISO)
                                                                 : running_crc);
            end
         end

         if (csr_write_enable) begin
            shadow_mode = crc_mode_type'(csr_crc_mode);
         end
      end
      mismatch_count <= fail_total;
      crcs_pending   <= expected_crc_q.size();
      crcs_checked   <= checked_total;
   end

endmodule

// File: tb/sv/crc64_bytewise_two_mode_unit_tb.sv
// Testbench top for the two-mode CRC-64 unit: clock, reset, stimulus and verdict.
module crc64_bytewise_two_mode_unit_tb;
   import crc64bt_pkg::*;

   localparam int unsigned CYCLE_LIMIT        = 400000;
   localparam int unsigned SETTLE_CYCLES      = 6;
   localparam int unsigned RANDOM_PHASES      = 7;
   localparam int unsigned REQUESTS_PER_PHASE = 200;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic                  csr_crc_mode;
   logic                  req_valid;
   logic                  req_stall;
   logic [BYTE_WIDTH-1:0] req_data_byte;
   logic                  req_start_flag;
   logic                  req_last_flag;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [CRC_WIDTH-1:0]  rsp_crc_value;

   int unsigned mismatch_count;
   int unsigned crcs_pending;
   int unsigned crcs_checked;
   int unsigned requests_sent;
   int unsigned mode_writes;
   int unsigned cycle_count;
   bit          idle_off;

   crc64_bytewise_two_mode_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_crc_mode     (csr_crc_mode),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_start_flag   (req_start_flag),
      .req_last_flag    (req_last_flag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_crc_value    (rsp_crc_value)
   );

   crc64_two_mode_checker crc_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_crc_mode     (csr_crc_mode),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_start_flag   (req_start_flag),
      .req_last_flag    (req_last_flag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_crc_value    (rsp_crc_value),
      .mismatch_count   (mismatch_count),
      .crcs_pending     (crcs_pending),
      .crcs_checked     (crcs_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net: a hung handshake ends the run as a failure.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Result-side stall: free-running stretches, some long, broken by stall bursts.
   initial begin : result_stall_driver
      int unsigned run_len;
      rsp_stall <= 1'b0;
      forever begin
         if (idle_off) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 20);
            rsp_stall <= 1'b0;
            repeat (run_len) @(posedge clock);
            if (!idle_off) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 15)) @(posedge clock);
            end
         end
      end
   end

   // Bytes skewed toward the all-zero and all-one patterns.
   function automatic logic [BYTE_WIDTH-1:0] random_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return BYTE_WIDTH'($urandom_range(0, 255));
      endcase
   endfunction

   // Offers one request, with an occasional idle burst first, and waits for acceptance.
   task automatic send_byte(
      input logic [BYTE_WIDTH-1:0] data,
      input logic                  start,
      input logic                  last
   );
      if (!idle_off && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= data;
      req_start_flag <= start;
      req_last_flag  <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   // A complete message from the characters of a string.
   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_byte(text[i], i == 0, i == text.len() - 1);
      end
   endtask

   // A complete message of random bytes.
   task automatic send_message(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) begin
         send_byte(random_byte(), i == 0, i == len - 1);
      end
   endtask

   // Waits until every expected CRC has arrived and the pipeline has emptied.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (crcs_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_crc_mode(input crc_mode_type mode);
      csr_write_enable <= 1'b1;
      csr_crc_mode     <= mode;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mode_writes++;
   endtask

   // Mostly well-formed messages, plus stray bytes and messages cut off before their end.
   task automatic random_phase(input int unsigned count);
      int unsigned sent_here;
      int unsigned len;
      int unsigned pick;
      sent_here = 0;
      while (sent_here < count) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            send_message(len);
            sent_here += len;
         end else if (pick == 8) begin
            send_byte(random_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent_here++;
         end else begin
            len = $urandom_range(1, 8);
            for (int unsigned i = 0; i < len; i++) begin
               send_byte(random_byte(), i == 0, 1'b0);
            end
            sent_here += len;
         end
      end
   endtask

   initial begin : stimulus
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_crc_mode     <= MODE_ECMA;
      req_valid        <= 1'b0;
      req_data_byte    <= '0;
      req_start_flag   <= 1'b0;
      req_last_flag    <= 1'b0;
      idle_off         <= 1'b0;
      requests_sent    = 0;
      mode_writes      = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ECMA mode from reset: a byte with no start absorbs into the cleared register.
      send_byte(8'hFF, 1'b0, 1'b1);
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_text("abc");
      // After a last byte the register keeps its unfinalized value.
      send_byte(8'h5A, 1'b0, 1'b1);
      // A message begun in ECMA mode and finished in ISO mode.
      send_byte(8'hA5, 1'b1, 1'b0);
      send_byte(8'h3C, 1'b0, 1'b0);
      drain_and_settle();
      write_crc_mode(MODE_ISO);
      send_byte(8'hC3, 1'b0, 1'b1);
      send_byte(8'h00, 1'b1, 1'b1);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_text("123456789");
      send_byte(8'h00, 1'b0, 1'b1);
      // And the other way round: begun in ISO mode, finished in ECMA mode.
      send_byte(8'h7E, 1'b1, 1'b0);
      drain_and_settle();
      write_crc_mode(MODE_ECMA);
      send_byte(8'h81, 1'b0, 1'b0);
      send_byte(8'h42, 1'b0, 1'b1);

      // Random phases alternate the mode; each boundary splits a message across it.
      for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
         if (p == RANDOM_PHASES - 1) begin
            idle_off <= 1'b1;
         end
         send_byte(random_byte(), 1'b1, 1'b0);
         drain_and_settle();
         write_crc_mode(crc_mode_type'((p + 1) % 2));
         send_byte(random_byte(), 1'b0, 1'b1);
         random_phase(REQUESTS_PER_PHASE);
      end

      drain_and_settle();
      $display("Run covered %0d requests in both CRC modes, %0d mode writes,",
               requests_sent, mode_writes);
      $display("and %0d CRC results compared against the prediction.", crcs_checked);
      if (mismatch_count == 0 && crcs_pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: crc64_bytewise_two_mode_unit.f
hw/rtl/crc64bt_pkg.sv
hw/rtl/crc64bt_in_reg.sv
hw/rtl/crc64bt_core.sv
hw/rtl/crc64bt_out_reg.sv
hw/rtl/crc64_bytewise_two_mode_unit.sv
tb/sv/crc64_two_mode_checker.sv
tb/sv/crc64_bytewise_two_mode_unit_tb.sv
